// ----- rtl/hermite_spline_point_engine_unit_macros.svh -----
// Assertion macros for the spline point engine RTL.
// No dependencies; included by modules that carry concurrent checks.
`ifndef HERMITE_SPLINE_POINT_ENGINE_UNIT_MACROS_SVH
`define HERMITE_SPLINE_POINT_ENGINE_UNIT_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define HSPE_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define HSPE_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/hspe_pkg.sv -----
// Shared types, codes and the rounding helper for the spline point engine.
// No dependencies.
package hspe_pkg;

   localparam int MAX_POINTS = 16;
   localparam int IDX_W      = 4;
   localparam int CNT_W      = 5;

   // Operation codes.
   localparam logic [2:0] OP_WRITE     = 3'd0;
   localparam logic [2:0] OP_INSERT    = 3'd1;
   localparam logic [2:0] OP_REMOVE    = 3'd2;
   localparam logic [2:0] OP_CLEAR     = 3'd3;
   localparam logic [2:0] OP_CARDINAL  = 3'd4;
   localparam logic [2:0] OP_EVAL_CUM  = 3'd5;
   localparam logic [2:0] OP_EVAL_NORM = 3'd6;
   localparam logic [2:0] OP_READ      = 3'd7;

   // Status codes.
   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_RANGE  = 2'd1;
   localparam logic [1:0] ST_FULL   = 2'd2;
   localparam logic [1:0] ST_TOOFEW = 2'd3;

   // Register indexes.
   localparam logic [2:0] REG_TENSION = 3'd0;
   localparam logic [2:0] REG_SVX     = 3'd1;
   localparam logic [2:0] REG_SVY     = 3'd2;
   localparam logic [2:0] REG_EVX     = 3'd3;
   localparam logic [2:0] REG_EVY     = 3'd4;

   // Memory write data sources.
   localparam logic [2:0] WR_MERGE  = 3'd0;
   localparam logic [2:0] WR_APPEND = 3'd1;
   localparam logic [2:0] WR_REQ    = 3'd2;
   localparam logic [2:0] WR_COPY   = 3'd3;
   localparam logic [2:0] WR_CARD   = 3'd4;

   // Multiplier operand selects. Codes 0 to 7 are the Hermite terms.
   localparam logic [3:0] MUL_H0X  = 4'd0;
   localparam logic [3:0] MUL_NORM = 4'd8;
   localparam logic [3:0] MUL_TT   = 4'd9;
   localparam logic [3:0] MUL_T2T  = 4'd10;
   localparam logic [3:0] MUL_CX   = 4'd11;
   localparam logic [3:0] MUL_CY   = 4'd12;

   // Tangent source for the cardinal operation.
   localparam logic [1:0] CARD_START = 2'd0;
   localparam logic [1:0] CARD_INNER = 2'd1;
   localparam logic [1:0] CARD_END   = 2'd2;

   // Accumulator operations.
   localparam logic [1:0] ACC_HOLD = 2'd0;
   localparam logic [1:0] ACC_LOAD = 2'd1;
   localparam logic [1:0] ACC_ADD  = 2'd2;

   // Result sources.
   localparam logic [1:0] OUT_ZERO  = 2'd0;
   localparam logic [1:0] OUT_RES   = 2'd1;
   localparam logic [1:0] OUT_RDATA = 2'd2;
   localparam logic [1:0] OUT_RDPOS = 2'd3;

   localparam logic signed [55:0] RND_MAX = 56'sd2147483647;
   localparam logic signed [55:0] RND_MIN = -56'sd2147483648;

   typedef struct packed {
      logic [16:0]        tension;
      logic signed [31:0] svx;
      logic signed [31:0] svy;
      logic signed [31:0] evx;
      logic signed [31:0] evy;
   } cfg_type;

   typedef struct packed {
      logic             load;
      logic             rd_en;
      logic [IDX_W-1:0] rd_addr;
      logic             wr_en;
      logic [IDX_W-1:0] wr_addr;
      logic [2:0]       wr_sel;
      logic [3:0]       mul_sel;
      logic [1:0]       card_kind;
      logic [CNT_W-1:0] segs;
      logic [1:0]       acc_op;
      logic             rnd_sh17;
      logic             st_a;
      logic             st_b;
      logic             cum_from_prod;
      logic             cum_from_param;
      logic             lat0;
      logic             lat1;
      logic             lat_t2;
      logic             lat_t3;
      logic             win_shift;
      logic             emit;
      logic [1:0]       out_sel;
   } dp_cmd_type;

   typedef struct packed {
      logic [7:0] seg;
      logic       loc_zero;
      logic       param_big;
   } dp_stat_type;

   typedef struct packed {
      logic        sat;
      logic [31:0] val;
   } rnd_type;

   // Round to nearest with halves upward, then clamp to 32 bits.
   function automatic rnd_type rnd_sat(input logic signed [55:0] v, input logic sh17);
      rnd_type r;
      logic signed [55:0] s;
      if (sh17) begin
         s = (v + 56'sd65536) >>> 17;
      end else begin
         s = (v + 56'sd32768) >>> 16;
      end
      r.sat = (s > RND_MAX) || (s < RND_MIN);
      if (s > RND_MAX) begin
         r.val = 32'h7FFF_FFFF;
      end else if (s < RND_MIN) begin
         r.val = 32'h8000_0000;
      end else begin
         r.val = s[31:0];
      end
      return r;
   endfunction

endpackage

// ----- rtl/hspe_csr.sv -----
// Configuration registers of the spline point engine behind an APB-style port.
// Depends on hspe_pkg.
module hspe_csr (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_psel,
   input  logic                csr_penable,
   input  logic                csr_pwrite,
   input  logic [4:0]          csr_paddr,
   input  logic [31:0]         csr_pwdata,
   output logic [31:0]         csr_prdata,
   output logic                csr_pready,
   output hspe_pkg::cfg_type   cfg
);

   hspe_pkg::cfg_type cfg_ff, cfg_in;
   logic              wr;

   assign wr         = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr) begin
         unique case (csr_paddr[4:2])
            hspe_pkg::REG_TENSION: cfg_in.tension = csr_pwdata[16:0];
            hspe_pkg::REG_SVX:     cfg_in.svx     = csr_pwdata;
            hspe_pkg::REG_SVY:     cfg_in.svy     = csr_pwdata;
            hspe_pkg::REG_EVX:     cfg_in.evx     = csr_pwdata;
            hspe_pkg::REG_EVY:     cfg_in.evy     = csr_pwdata;
            default:               cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[4:2])
         hspe_pkg::REG_TENSION: csr_prdata = {15'd0, cfg_ff.tension};
         hspe_pkg::REG_SVX:     csr_prdata = cfg_ff.svx;
         hspe_pkg::REG_SVY:     csr_prdata = cfg_ff.svy;
         hspe_pkg::REG_EVX:     csr_prdata = cfg_ff.evx;
         hspe_pkg::REG_EVY:     csr_prdata = cfg_ff.evy;
         default:               csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ----- rtl/hspe_dp.sv -----
// Datapath: point memory, tangent window, shared multiplier, accumulator, results.
// Depends on hspe_pkg; driven by hspe_ctrl.
module hspe_dp (
   input  logic                    clock,
   input  hspe_pkg::cfg_type       cfg,
   input  hspe_pkg::dp_cmd_type    cmd,
   output hspe_pkg::dp_stat_type   stat,
   input  logic signed [31:0]      req_pos_x,
   input  logic signed [31:0]      req_pos_y,
   input  logic signed [31:0]      req_vel_x,
   input  logic signed [31:0]      req_vel_y,
   input  logic                    req_write_position,
   input  logic                    req_write_velocity,
   input  logic [23:0]             req_param,
   output logic signed [31:0]      rsp_out_x,
   output logic signed [31:0]      rsp_out_y,
   output logic signed [31:0]      rsp_out_vel_x,
   output logic signed [31:0]      rsp_out_vel_y,
   output logic                    rsp_saturated
);

   // Request payload.
   logic signed [31:0] px_ff, py_ff, vx_ff, vy_ff;
   logic               wp_ff, wv_ff;
   logic [23:0]        param_ff;

   // Point memory, one word per point: {pos_x, pos_y, vel_x, vel_y}.
   logic [127:0] mem_ff [hspe_pkg::MAX_POINTS];
   logic [127:0] rdata_ff;
   logic [127:0] wdata;
   logic [31:0]  rd_px, rd_py, rd_vx, rd_vy;

   // Position window for the cardinal tangents: previous, current, next.
   logic signed [31:0] w0x_ff, w0y_ff, w1x_ff, w1y_ff, w2x_ff, w2y_ff;

   logic [23:0]        cum_ff;
   logic [15:0]        t2_ff, t3_ff;
   logic [127:0]       seg0_ff, seg1_ff;
   logic signed [32:0] mul_a;
   logic signed [18:0] mul_b;
   logic signed [51:0] prod_ff;
   logic signed [55:0] acc_ff;
   logic signed [55:0] prod_ext;
   logic signed [31:0] res_a_ff, res_b_ff;
   logic               sat_ff;
   logic [16:0]        m_val;
   logic [15:0]        t_val;
   logic signed [19:0] h01_w, h00_w, h10_w, h11_w;
   logic signed [18:0] coef;
   logic [31:0]        hdata;
   logic signed [31:0] cvx, cvy;
   hspe_pkg::rnd_type  rnd;

   assign rd_px = rdata_ff[127:96];
   assign rd_py = rdata_ff[95:64];
   assign rd_vx = rdata_ff[63:32];
   assign rd_vy = rdata_ff[31:0];

   // A tension of one or more leaves a zero scale.
   assign m_val = cfg.tension[16] ? 17'd0 : 17'd65536 - cfg.tension;
   assign t_val = cum_ff[15:0];

   assign h01_w = 20'sd3 * $signed({4'd0, t2_ff}) - 20'sd2 * $signed({4'd0, t3_ff});
   assign h00_w = 20'sd65536 - h01_w;
   assign h10_w = $signed({4'd0, t3_ff}) - 20'sd2 * $signed({4'd0, t2_ff})
                  + $signed({4'd0, t_val});
   assign h11_w = $signed({4'd0, t3_ff}) - $signed({4'd0, t2_ff});

   always_comb begin
      case (cmd.wr_sel)
         hspe_pkg::WR_MERGE:  wdata = {wp_ff ? px_ff : rd_px, wp_ff ? py_ff : rd_py,
                                       wv_ff ? vx_ff : rd_vx, wv_ff ? vy_ff : rd_vy};
         hspe_pkg::WR_APPEND: wdata = {wp_ff ? px_ff : 32'd0, wp_ff ? py_ff : 32'd0,
                                       wv_ff ? vx_ff : 32'd0, wv_ff ? vy_ff : 32'd0};
         hspe_pkg::WR_REQ:    wdata = {px_ff, py_ff, vx_ff, vy_ff};
         hspe_pkg::WR_COPY:   wdata = rdata_ff;
         hspe_pkg::WR_CARD:   wdata = {w1x_ff, w1y_ff, res_a_ff, res_b_ff};
         default:             wdata = rdata_ff;
      endcase
   end

   always_comb begin
      case (cmd.mul_sel[1:0])
         2'd0:    coef = h00_w[18:0];
         2'd1:    coef = h10_w[18:0];
         2'd2:    coef = h01_w[18:0];
         default: coef = h11_w[18:0];
      endcase
      if (cmd.mul_sel[2]) begin
         case (cmd.mul_sel[1:0])
            2'd0:    hdata = seg0_ff[95:64];
            2'd1:    hdata = seg0_ff[31:0];
            2'd2:    hdata = seg1_ff[95:64];
            default: hdata = seg1_ff[31:0];
         endcase
      end else begin
         case (cmd.mul_sel[1:0])
            2'd0:    hdata = seg0_ff[127:96];
            2'd1:    hdata = seg0_ff[63:32];
            2'd2:    hdata = seg1_ff[127:96];
            default: hdata = seg1_ff[63:32];
         endcase
      end
      cvx = (cmd.card_kind == hspe_pkg::CARD_START) ? cfg.svx : cfg.evx;
      cvy = (cmd.card_kind == hspe_pkg::CARD_START) ? cfg.svy : cfg.evy;
   end

   always_comb begin
      mul_a = {hdata[31], hdata};
      mul_b = coef;
      case (cmd.mul_sel)
         hspe_pkg::MUL_NORM: begin
            mul_a = {28'd0, cmd.segs};
            mul_b = {2'd0, param_ff[16:0]};
         end
         hspe_pkg::MUL_TT: begin
            mul_a = {17'd0, t_val};
            mul_b = {3'd0, t_val};
         end
         hspe_pkg::MUL_T2T: begin
            mul_a = {17'd0, t2_ff};
            mul_b = {3'd0, t_val};
         end
         hspe_pkg::MUL_CX: begin
            mul_b = {2'd0, m_val};
            if (cmd.card_kind == hspe_pkg::CARD_INNER) begin
               mul_a = {w2x_ff[31], w2x_ff} - {w0x_ff[31], w0x_ff};
            end else begin
               mul_a = {cvx[31], cvx};
            end
         end
         hspe_pkg::MUL_CY: begin
            mul_b = {2'd0, m_val};
            if (cmd.card_kind == hspe_pkg::CARD_INNER) begin
               mul_a = {w2y_ff[31], w2y_ff} - {w0y_ff[31], w0y_ff};
            end else begin
               mul_a = {cvy[31], cvy};
            end
         end
         default: begin
            mul_a = {hdata[31], hdata};
            mul_b = coef;
         end
      endcase
   end

   assign prod_ext = {{4{prod_ff[51]}}, prod_ff};
   assign rnd      = hspe_pkg::rnd_sat(acc_ff, cmd.rnd_sh17);

   assign stat.seg       = cum_ff[23:16];
   assign stat.loc_zero  = (cum_ff[15:0] == 16'd0);
   assign stat.param_big = (param_ff > 24'd65536);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         px_ff    <= req_pos_x;
         py_ff    <= req_pos_y;
         vx_ff    <= req_vel_x;
         vy_ff    <= req_vel_y;
         wp_ff    <= req_write_position;
         wv_ff    <= req_write_velocity;
         param_ff <= req_param;
      end
      if (cmd.wr_en) begin
         mem_ff[cmd.wr_addr] <= wdata;
      end
      if (cmd.rd_en) begin
         rdata_ff <= mem_ff[cmd.rd_addr];
      end
      if (cmd.win_shift) begin
         w0x_ff <= w1x_ff;
         w0y_ff <= w1y_ff;
         w1x_ff <= w2x_ff;
         w1y_ff <= w2y_ff;
         w2x_ff <= rd_px;
         w2y_ff <= rd_py;
      end
      if (cmd.cum_from_param) begin
         cum_ff <= param_ff;
      end else if (cmd.cum_from_prod) begin
         cum_ff <= prod_ff[23:0];
      end
      if (cmd.lat0) begin
         seg0_ff <= rdata_ff;
      end
      if (cmd.lat1) begin
         seg1_ff <= rdata_ff;
      end
      if (cmd.lat_t2) begin
         t2_ff <= prod_ff[31:16];
      end
      if (cmd.lat_t3) begin
         t3_ff <= prod_ff[31:16];
      end
      prod_ff <= mul_a * mul_b;
      case (cmd.acc_op)
         hspe_pkg::ACC_LOAD: acc_ff <= prod_ext;
         hspe_pkg::ACC_ADD:  acc_ff <= acc_ff + prod_ext;
         default:            acc_ff <= acc_ff;
      endcase
      if (cmd.st_a) begin
         res_a_ff <= rnd.val;
      end
      if (cmd.st_b) begin
         res_b_ff <= rnd.val;
      end
      if (cmd.load) begin
         sat_ff <= 1'b0;
      end else if (cmd.st_a || cmd.st_b) begin
         sat_ff <= sat_ff | rnd.sat;
      end
      if (cmd.emit) begin
         rsp_saturated <= sat_ff;
         case (cmd.out_sel)
            hspe_pkg::OUT_RES: begin
               rsp_out_x     <= res_a_ff;
               rsp_out_y     <= res_b_ff;
               rsp_out_vel_x <= 32'sd0;
               rsp_out_vel_y <= 32'sd0;
            end
            hspe_pkg::OUT_RDATA: begin
               rsp_out_x     <= rd_px;
               rsp_out_y     <= rd_py;
               rsp_out_vel_x <= rd_vx;
               rsp_out_vel_y <= rd_vy;
            end
            hspe_pkg::OUT_RDPOS: begin
               rsp_out_x     <= rd_px;
               rsp_out_y     <= rd_py;
               rsp_out_vel_x <= 32'sd0;
               rsp_out_vel_y <= 32'sd0;
            end
            default: begin
               rsp_out_x     <= 32'sd0;
               rsp_out_y     <= 32'sd0;
               rsp_out_vel_x <= 32'sd0;
               rsp_out_vel_y <= 32'sd0;
            end
         endcase
      end
   end

endmodule

// ----- rtl/hspe_ctrl.sv -----
// Controller: sequences each operation, holds the point count and the result beat.
// Depends on hspe_pkg and the assertion macros; drives hspe_dp.
`include "hermite_spline_point_engine_unit_macros.svh"

module hspe_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [2:0]              req_op,
   input  logic [3:0]              req_index,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [4:0]              rsp_point_total,
   output logic [1:0]              rsp_status,
   input  hspe_pkg::dp_stat_type   stat,
   output hspe_pkg::dp_cmd_type    cmd
);

   localparam logic [4:0] S_IDLE    = 5'd0;
   localparam logic [4:0] S_DECODE  = 5'd1;
   localparam logic [4:0] S_WR_UPD  = 5'd2;
   localparam logic [4:0] S_WR_APP  = 5'd3;
   localparam logic [4:0] S_INS_RD  = 5'd4;
   localparam logic [4:0] S_INS_WR  = 5'd5;
   localparam logic [4:0] S_INS_PUT = 5'd6;
   localparam logic [4:0] S_REM_RD  = 5'd7;
   localparam logic [4:0] S_REM_WR  = 5'd8;
   localparam logic [4:0] S_C_PRE   = 5'd9;
   localparam logic [4:0] S_C_RD    = 5'd10;
   localparam logic [4:0] S_C_SHIFT = 5'd11;
   localparam logic [4:0] S_C_MX    = 5'd12;
   localparam logic [4:0] S_C_MY    = 5'd13;
   localparam logic [4:0] S_C_SX    = 5'd14;
   localparam logic [4:0] S_C_SY    = 5'd15;
   localparam logic [4:0] S_C_WR    = 5'd16;
   localparam logic [4:0] S_E_NORM  = 5'd17;
   localparam logic [4:0] S_E_CHK   = 5'd18;
   localparam logic [4:0] S_E_R0    = 5'd19;
   localparam logic [4:0] S_E_R1    = 5'd20;
   localparam logic [4:0] S_E_T3    = 5'd21;
   localparam logic [4:0] S_E_T3W   = 5'd22;
   localparam logic [4:0] S_E_SUM   = 5'd23;
   localparam logic [4:0] S_DONE    = 5'd24;

   logic [4:0] state_ff, state_in;
   logic [2:0] op_ff, op_in;
   logic [3:0] idx_ff, idx_in;
   logic [4:0] count_ff, count_in;
   logic [3:0] i_ff, i_in;
   logic [3:0] s_ff, s_in;
   logic [1:0] st_ff, st_in;
   logic [1:0] osel_ff, osel_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [4:0] total_ff, total_in;
   logic [1:0] status_ff, status_in;
   logic [4:0] segs;
   logic [3:0] last;
   logic [1:0] kind;

   assign req_stall       = (state_ff != S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_point_total = total_ff;
   assign rsp_status      = status_ff;

   assign segs = count_ff - 5'd1;
   assign last = segs[3:0];

   always_comb begin
      if (i_ff == 4'd0) begin
         kind = hspe_pkg::CARD_START;
      end else if (i_ff == last) begin
         kind = hspe_pkg::CARD_END;
      end else begin
         kind = hspe_pkg::CARD_INNER;
      end
   end

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      idx_in       = idx_ff;
      count_in     = count_ff;
      i_in         = i_ff;
      s_in         = s_ff;
      st_in        = st_ff;
      osel_in      = osel_ff;
      total_in     = total_ff;
      status_in    = status_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd          = '0;
      cmd.segs     = segs;
      cmd.out_sel  = osel_ff;
      cmd.card_kind = kind;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               op_in    = req_op;
               idx_in   = req_index;
               st_in    = hspe_pkg::ST_OK;
               osel_in  = hspe_pkg::OUT_ZERO;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            state_in = S_DONE;
            unique case (op_ff)
               hspe_pkg::OP_WRITE: begin
                  if ({1'b0, idx_ff} > count_ff) begin
                     st_in = hspe_pkg::ST_RANGE;
                  end else if ({1'b0, idx_ff} == count_ff) begin
                     if (count_ff >= 5'(hspe_pkg::MAX_POINTS)) begin
                        st_in = hspe_pkg::ST_FULL;
                     end else begin
                        state_in = S_WR_APP;
                     end
                  end else begin
                     cmd.rd_en   = 1'b1;
                     cmd.rd_addr = idx_ff;
                     state_in    = S_WR_UPD;
                  end
               end
               hspe_pkg::OP_INSERT: begin
                  if ({1'b0, idx_ff} > count_ff) begin
                     st_in = hspe_pkg::ST_RANGE;
                  end else if (count_ff >= 5'(hspe_pkg::MAX_POINTS)) begin
                     st_in = hspe_pkg::ST_FULL;
                  end else begin
                     i_in     = count_ff[3:0];
                     state_in = (count_ff[3:0] > idx_ff) ? S_INS_RD : S_INS_PUT;
                  end
               end
               hspe_pkg::OP_REMOVE: begin
                  if ({1'b0, idx_ff} >= count_ff) begin
                     st_in = hspe_pkg::ST_RANGE;
                  end else if (({1'b0, idx_ff} + 5'd1) < count_ff) begin
                     i_in     = idx_ff;
                     state_in = S_REM_RD;
                  end else begin
                     count_in = count_ff - 5'd1;
                  end
               end
               hspe_pkg::OP_CLEAR: begin
                  count_in = 5'd0;
               end
               hspe_pkg::OP_CARDINAL: begin
                  if (count_ff < 5'd2) begin
                     st_in = hspe_pkg::ST_TOOFEW;
                  end else begin
                     cmd.rd_en   = 1'b1;
                     cmd.rd_addr = 4'd0;
                     state_in    = S_C_PRE;
                  end
               end
               hspe_pkg::OP_EVAL_CUM: begin
                  if (count_ff < 5'd2) begin
                     st_in = hspe_pkg::ST_TOOFEW;
                  end else begin
                     cmd.cum_from_param = 1'b1;
                     state_in           = S_E_CHK;
                  end
               end
               hspe_pkg::OP_EVAL_NORM: begin
                  if (count_ff < 5'd2) begin
                     st_in = hspe_pkg::ST_TOOFEW;
                  end else if (stat.param_big) begin
                     st_in = hspe_pkg::ST_RANGE;
                  end else begin
                     cmd.mul_sel = hspe_pkg::MUL_NORM;
                     state_in    = S_E_NORM;
                  end
               end
               hspe_pkg::OP_READ: begin
                  if ({1'b0, idx_ff} >= count_ff) begin
                     st_in = hspe_pkg::ST_RANGE;
                  end else begin
                     cmd.rd_en   = 1'b1;
                     cmd.rd_addr = idx_ff;
                     osel_in     = hspe_pkg::OUT_RDATA;
                  end
               end
               default: state_in = S_DONE;
            endcase
         end
         S_WR_UPD: begin
            cmd.wr_en   = 1'b1;
            cmd.wr_addr = idx_ff;
            cmd.wr_sel  = hspe_pkg::WR_MERGE;
            state_in    = S_DONE;
         end
         S_WR_APP: begin
            cmd.wr_en   = 1'b1;
            cmd.wr_addr = idx_ff;
            cmd.wr_sel  = hspe_pkg::WR_APPEND;
            count_in    = count_ff + 5'd1;
            state_in    = S_DONE;
         end
         S_INS_RD: begin
            cmd.rd_en   = 1'b1;
            cmd.rd_addr = i_ff - 4'd1;
            state_in    = S_INS_WR;
         end
         S_INS_WR: begin
            cmd.wr_en   = 1'b1;
            cmd.wr_addr = i_ff;
            cmd.wr_sel  = hspe_pkg::WR_COPY;
            i_in        = i_ff - 4'd1;
            state_in    = ((i_ff - 4'd1) > idx_ff) ? S_INS_RD : S_INS_PUT;
         end
         S_INS_PUT: begin
            cmd.wr_en   = 1'b1;
            cmd.wr_addr = idx_ff;
            cmd.wr_sel  = hspe_pkg::WR_REQ;
            count_in    = count_ff + 5'd1;
            state_in    = S_DONE;
         end
         S_REM_RD: begin
            cmd.rd_en   = 1'b1;
            cmd.rd_addr = i_ff + 4'd1;
            state_in    = S_REM_WR;
         end
         S_REM_WR: begin
            cmd.wr_en   = 1'b1;
            cmd.wr_addr = i_ff;
            cmd.wr_sel  = hspe_pkg::WR_COPY;
            if (({1'b0, i_ff} + 5'd2) < count_ff) begin
               i_in     = i_ff + 4'd1;
               state_in = S_REM_RD;
            end else begin
               count_in = count_ff - 5'd1;
               state_in = S_DONE;
            end
         end
         S_C_PRE: begin
            cmd.win_shift = 1'b1;
            i_in          = 4'd0;
            state_in      = S_C_RD;
         end
         S_C_RD: begin
            // On the last point this fetch is not used; the window only needs current.
            cmd.rd_en   = 1'b1;
            cmd.rd_addr = i_ff + 4'd1;
            state_in    = S_C_SHIFT;
         end
         S_C_SHIFT: begin
            cmd.win_shift = 1'b1;
            state_in      = S_C_MX;
         end
         S_C_MX: begin
            cmd.mul_sel = hspe_pkg::MUL_CX;
            state_in    = S_C_MY;
         end
         S_C_MY: begin
            cmd.mul_sel = hspe_pkg::MUL_CY;
            cmd.acc_op  = hspe_pkg::ACC_LOAD;
            state_in    = S_C_SX;
         end
         S_C_SX: begin
            cmd.st_a     = 1'b1;
            cmd.rnd_sh17 = (kind == hspe_pkg::CARD_INNER);
            cmd.acc_op   = hspe_pkg::ACC_LOAD;
            state_in     = S_C_SY;
         end
         S_C_SY: begin
            cmd.st_b     = 1'b1;
            cmd.rnd_sh17 = (kind == hspe_pkg::CARD_INNER);
            state_in     = S_C_WR;
         end
         S_C_WR: begin
            cmd.wr_en   = 1'b1;
            cmd.wr_addr = i_ff;
            cmd.wr_sel  = hspe_pkg::WR_CARD;
            if (i_ff == last) begin
               state_in = S_DONE;
            end else begin
               i_in     = i_ff + 4'd1;
               state_in = S_C_RD;
            end
         end
         S_E_NORM: begin
            cmd.cum_from_prod = 1'b1;
            state_in          = S_E_CHK;
         end
         S_E_CHK: begin
            if (stat.seg >= {3'd0, segs}) begin
               state_in = S_DONE;
               // Exactly the end of the curve gives the last stored position.
               if ((stat.seg == {3'd0, segs}) && stat.loc_zero) begin
                  cmd.rd_en   = 1'b1;
                  cmd.rd_addr = last;
                  osel_in     = hspe_pkg::OUT_RDPOS;
               end else begin
                  st_in = hspe_pkg::ST_RANGE;
               end
            end else begin
               cmd.rd_en   = 1'b1;
               cmd.rd_addr = stat.seg[3:0];
               state_in    = S_E_R0;
            end
         end
         S_E_R0: begin
            cmd.lat0    = 1'b1;
            cmd.rd_en   = 1'b1;
            cmd.rd_addr = stat.seg[3:0] + 4'd1;
            cmd.mul_sel = hspe_pkg::MUL_TT;
            state_in    = S_E_R1;
         end
         S_E_R1: begin
            cmd.lat1   = 1'b1;
            cmd.lat_t2 = 1'b1;
            state_in   = S_E_T3;
         end
         S_E_T3: begin
            cmd.mul_sel = hspe_pkg::MUL_T2T;
            state_in    = S_E_T3W;
         end
         S_E_T3W: begin
            cmd.lat_t3 = 1'b1;
            s_in       = 4'd0;
            state_in   = S_E_SUM;
         end
         S_E_SUM: begin
            // Eight products issue on steps 0 to 7 and accumulate one step later;
            // x is rounded out on step 5 while the y sum starts.
            cmd.mul_sel = hspe_pkg::MUL_H0X + {1'b0, s_ff[2:0]};
            if ((s_ff == 4'd1) || (s_ff == 4'd5)) begin
               cmd.acc_op = hspe_pkg::ACC_LOAD;
            end else if ((s_ff != 4'd0) && (s_ff != 4'd9)) begin
               cmd.acc_op = hspe_pkg::ACC_ADD;
            end
            cmd.st_a = (s_ff == 4'd5);
            cmd.st_b = (s_ff == 4'd9);
            if (s_ff == 4'd9) begin
               osel_in  = hspe_pkg::OUT_RES;
               state_in = S_DONE;
            end else begin
               s_in = s_ff + 4'd1;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.emit     = 1'b1;
               rsp_valid_in = 1'b1;
               total_in     = count_ff;
               status_in    = st_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= 5'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      idx_ff    <= idx_in;
      i_ff      <= i_in;
      s_ff      <= s_in;
      st_ff     <= st_in;
      osel_ff   <= osel_in;
      total_ff  <= total_in;
      status_ff <= status_in;
   end

   `HSPE_ASSERT_NEXT(a_count_idle, clock, reset, state_ff == S_IDLE, $stable(count_ff), "point count changed while idle")
   `HSPE_ASSERT_NOW(a_count_max, clock, reset, 1'b1, count_ff <= 5'(hspe_pkg::MAX_POINTS), "point count above table size")
   `HSPE_ASSERT_NOW(a_wr_bound, clock, reset, cmd.wr_en, {1'b0, cmd.wr_addr} <= count_ff, "memory write beyond the stored points")
   `HSPE_ASSERT_NOW(a_eval_pts, clock, reset, state_ff == S_E_SUM, count_ff >= 5'd2, "curve evaluated with fewer than two points")

endmodule

// ----- rtl/hermite_spline_point_engine_unit.sv -----
// Hermite spline point engine: table of up to 16 control points with cubic evaluation.
// One item at a time: a new request is taken only once the engine is idle again, after
// the result beat of the last one has been issued. Insert and remove move the stored
// points one by one, and cardinal tangents are computed point by point.
// The result beat turns valid in the same cycle the engine can accept again, later while the output stalls.
// Synchronous reset clears count, configuration registers and handshake; point data is left as is.
module hermite_spline_point_engine_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [2:0]         req_op,
   input  logic [3:0]         req_index,
   input  logic signed [31:0] req_pos_x,
   input  logic signed [31:0] req_pos_y,
   input  logic signed [31:0] req_vel_x,
   input  logic signed [31:0] req_vel_y,
   input  logic               req_write_position,
   input  logic               req_write_velocity,
   input  logic [23:0]        req_param,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_out_x,
   output logic signed [31:0] rsp_out_y,
   output logic signed [31:0] rsp_out_vel_x,
   output logic signed [31:0] rsp_out_vel_y,
   output logic [4:0]         rsp_point_total,
   output logic [1:0]         rsp_status,
   output logic               rsp_saturated,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [4:0]         csr_paddr,
   input  logic [31:0]        csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready
);

   hspe_pkg::cfg_type     cfg;
   hspe_pkg::dp_cmd_type  cmd;
   hspe_pkg::dp_stat_type stat;

   hspe_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   hspe_ctrl u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_op          (req_op),
      .req_index       (req_index),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_point_total (rsp_point_total),
      .rsp_status      (rsp_status),
      .stat            (stat),
      .cmd             (cmd)
   );

   hspe_dp u_dp (
      .clock              (clock),
      .cfg                (cfg),
      .cmd                (cmd),
      .stat               (stat),
      .req_pos_x          (req_pos_x),
      .req_pos_y          (req_pos_y),
      .req_vel_x          (req_vel_x),
      .req_vel_y          (req_vel_y),
      .req_write_position (req_write_position),
      .req_write_velocity (req_write_velocity),
      .req_param          (req_param),
      .rsp_out_x          (rsp_out_x),
      .rsp_out_y          (rsp_out_y),
      .rsp_out_vel_x      (rsp_out_vel_x),
      .rsp_out_vel_y      (rsp_out_vel_y),
      .rsp_saturated      (rsp_saturated)
   );

endmodule
